### rtl/core/ppid_pkg.sv
package ppid_pkg;

  // Clamp magnitude of the derivative term
  localparam logic [14:0] LimitD = 15'd32767;

  // Integral operand of the I multiplier: any |integral| at or above 2^23 already
  // drives the term into its clamp for every nonzero gain.
  localparam int AccMulW   = 25;
  localparam int AccMulLim = 8388608;

  typedef enum logic [2:0] {
    RegSetpoint     = 3'd0,
    RegGainP        = 3'd1,
    RegGainI        = 3'd2,
    RegGainD        = 3'd3,
    RegSepThreshold = 3'd4,
    RegLimitP       = 3'd5,
    RegLimitI       = 3'd6,
    RegLimitTotal   = 3'd7
  } ppid_reg_e;

  typedef struct packed {
    logic signed [15:0] setpoint;
    logic signed [15:0] gain_p;
    logic signed [15:0] gain_i;
    logic signed [15:0] gain_d;
    logic signed [16:0] sep_threshold;
    logic        [14:0] limit_p;
    logic        [14:0] limit_i;
    logic        [14:0] limit_total;
  } ppid_cfg_t;

  typedef struct packed {
    logic signed [16:0]        err;
    logic signed [17:0]        derr;
    logic signed [AccMulW-1:0] acc;
    logic                      sep_zero;
  } ppid_err_t;

  typedef struct packed {
    logic signed [15:0] tp;
    logic signed [15:0] ti;
    logic signed [15:0] td;
  } ppid_terms_t;

  function automatic logic signed [15:0] clamp_sym(input logic signed [33:0] x,
                                                   input logic [14:0] lim);
    logic signed [33:0] lim_x;
    lim_x = signed'({19'd0, lim});
    if (x > lim_x) begin
      return signed'({1'b0, lim});
    end else if (x < -lim_x) begin
      return -signed'({1'b0, lim});
    end else begin
      return 16'(x);
    end
  endfunction

endpackage

### rtl/core/ppid_front.sv
module ppid_front #(
  parameter int INTEGRAL_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ppid_pkg::ppid_cfg_t cfg_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic               cmd_i,
  input  logic signed [15:0] sample_i,
  output logic               valid_o,
  input  logic               ready_i,
  output ppid_pkg::ppid_err_t data_o
);
  import ppid_pkg::*;

  localparam int IW = INTEGRAL_WIDTH;
  localparam int XW = (IW > AccMulW) ? IW : AccMulW;
  localparam logic signed [IW-1:0] IntMax = signed'({1'b0, {(IW-1){1'b1}}});
  localparam logic signed [IW-1:0] IntMin = signed'({1'b1, {(IW-1){1'b0}}});
  localparam logic signed [XW-1:0] AccHi  = XW'(AccMulLim);
  localparam logic signed [XW-1:0] AccLo  = -AccHi;

  logic signed [IW-1:0] integral_q, integral_d;
  logic signed [16:0]   prev_err_q;
  logic signed [16:0]   err;
  logic signed [IW:0]   sum;
  logic signed [XW-1:0] acc_x;
  logic                 valid_q;
  logic                 accept;
  ppid_err_t            data_q, data_d;

  assign ready_o = !valid_q || ready_i;
  assign accept  = valid_i && ready_o;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    if (cmd_i) begin
      err = 17'(sample_i);
    end else begin
      err = 17'(cfg_i.setpoint) - 17'(sample_i);
    end
    sum = (IW+1)'(integral_q) + (IW+1)'(err);
    // saturate on overflow of the top bit
    if (sum[IW] != sum[IW-1]) begin
      integral_d = sum[IW] ? IntMin : IntMax;
    end else begin
      integral_d = IW'(sum);
    end
    acc_x = XW'(integral_d);
    if (acc_x > AccHi) begin
      acc_x = AccHi;
    end else if (acc_x < AccLo) begin
      acc_x = AccLo;
    end
    data_d.err      = err;
    data_d.derr     = 18'(err) - 18'(prev_err_q);
    data_d.acc      = AccMulW'(acc_x);
    data_d.sep_zero = !cmd_i && (err < cfg_i.sep_threshold);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      integral_q <= '0;
      prev_err_q <= '0;
    end else begin
      if (ready_o) begin
        valid_q <= valid_i;
      end
      if (accept) begin
        integral_q <= integral_d;
        prev_err_q <= err;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= data_d;
    end
  end

endmodule

### rtl/core/ppid_terms.sv
module ppid_terms (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ppid_pkg::ppid_cfg_t   cfg_i,
  input  logic                valid_i,
  output logic                ready_o,
  input  ppid_pkg::ppid_err_t   data_i,
  output logic                valid_o,
  input  logic                ready_i,
  output ppid_pkg::ppid_terms_t data_o
);
  import ppid_pkg::*;

  logic signed [32:0] prod_p;
  logic signed [40:0] prod_i;
  logic signed [33:0] prod_d;
  logic               valid_q;
  ppid_terms_t        data_q, data_d;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  // Q8.8 gains: arithmetic shift by 8 floors the product
  always_comb begin
    prod_p = cfg_i.gain_p * data_i.err;
    prod_i = cfg_i.gain_i * data_i.acc;
    prod_d = cfg_i.gain_d * data_i.derr;
    data_d.tp = clamp_sym(34'(prod_p >>> 8), cfg_i.limit_p);
    data_d.ti = data_i.sep_zero ? 16'sd0 : clamp_sym(34'(prod_i >>> 8), cfg_i.limit_i);
    data_d.td = clamp_sym(34'(prod_d >>> 8), LimitD);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

### rtl/core/ppid_sum.sv
module ppid_sum (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [14:0]         limit_total_i,
  input  logic                valid_i,
  output logic                ready_o,
  input  ppid_pkg::ppid_terms_t data_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic signed [15:0]  drive_o
);
  import ppid_pkg::*;

  logic signed [17:0] sum;
  logic signed [15:0] drive_q, drive_d;
  logic               valid_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign drive_o = drive_q;

  always_comb begin
    sum     = 18'(data_i.tp) + 18'(data_i.ti) + 18'(data_i.td);
    drive_d = clamp_sym(34'(sum), limit_total_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      drive_q <= drive_d;
    end
  end

endmodule

### rtl/core/position_pid_controller_unit.sv
// Channel  | Handshake                  | Payload
// ---------+----------------------------+------------------------------
// input    | in_valid_i / in_ready_o    | cmd_i, sample_i
// output   | out_valid_o / out_ready_i  | drive_o
// config   | cfg_we_i (no wait)         | cfg_idx_i, cfg_wdata_i
//
// One beat per cycle sustained while out_ready_i stays high.
// Stage 1 updates error, integral and previous error; stage 2 does the three
// gain multiplies and term clamps; stage 3 sums and clamps the drive.
// Reset clears integral, prev error, valid bits, config; limits go to max.
// Each stage advances when the next one is empty or moving, so bubbles fill
// while the output holds a beat.
module position_pid_controller_unit #(
  parameter int INTEGRAL_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [16:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               cmd_i,
  input  logic signed [15:0] sample_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] drive_o
);
  import ppid_pkg::*;

  ppid_cfg_t   cfg_q;
  ppid_err_t   err_data;
  ppid_terms_t term_data;
  logic        err_valid, err_ready;
  logic        term_valid, term_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.setpoint      <= '0;
      cfg_q.gain_p        <= '0;
      cfg_q.gain_i        <= '0;
      cfg_q.gain_d        <= '0;
      cfg_q.sep_threshold <= '0;
      cfg_q.limit_p       <= 15'h7fff;
      cfg_q.limit_i       <= 15'h7fff;
      cfg_q.limit_total   <= 15'h7fff;
    end else if (cfg_we_i) begin
      case (ppid_reg_e'(cfg_idx_i))
        RegSetpoint:     cfg_q.setpoint      <= signed'(cfg_wdata_i[15:0]);
        RegGainP:        cfg_q.gain_p        <= signed'(cfg_wdata_i[15:0]);
        RegGainI:        cfg_q.gain_i        <= signed'(cfg_wdata_i[15:0]);
        RegGainD:        cfg_q.gain_d        <= signed'(cfg_wdata_i[15:0]);
        RegSepThreshold: cfg_q.sep_threshold <= signed'(cfg_wdata_i);
        RegLimitP:       cfg_q.limit_p       <= cfg_wdata_i[14:0];
        RegLimitI:       cfg_q.limit_i       <= cfg_wdata_i[14:0];
        RegLimitTotal:   cfg_q.limit_total   <= cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  ppid_front #(
    .INTEGRAL_WIDTH(INTEGRAL_WIDTH)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .cmd_i   (cmd_i),
    .sample_i(sample_i),
    .valid_o (err_valid),
    .ready_i (err_ready),
    .data_o  (err_data)
  );

  ppid_terms u_terms (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .valid_i(err_valid),
    .ready_o(err_ready),
    .data_i (err_data),
    .valid_o(term_valid),
    .ready_i(term_ready),
    .data_o (term_data)
  );

  ppid_sum u_sum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .limit_total_i(cfg_q.limit_total),
    .valid_i      (term_valid),
    .ready_o      (term_ready),
    .data_i       (term_data),
    .valid_o      (out_valid_o),
    .ready_i      (out_ready_i),
    .drive_o      (drive_o)
  );

endmodule

### rtl/core/ppid_checker.sv
module ppid_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               cmd_i,
  input logic signed [15:0] sample_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [15:0] drive_o
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(drive_o))
    else $error("output beat dropped or changed while stalled");

  // a stalled input beat keeps its payload
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(cmd_i) && $stable(sample_i))
    else $error("input beat dropped or changed while stalled");

  // the clamps are symmetric, so the most negative code never appears
  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> drive_o != 16'sh8000)
    else $error("drive outside symmetric range");

  // an accepted beat must show a valid output once through the front, terms and sum registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> ##3 out_valid_o)
    else $error("result missing three cycles after accept");

  // a free output frees the whole pipe
  a_ready_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while output is ready");

endmodule

bind position_pid_controller_unit ppid_checker u_chk (.*);

### sim/ppid_drive_checker.sv
module ppid_drive_checker #(
  parameter int IntegralW = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [16:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               cmd_i,
  input  logic signed [15:0] sample_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [15:0] drive_i,
  output int                 fail_cnt_o,
  output int                 pending_o
);
  import ppid_pkg::*;

  localparam longint IntegMax = (longint'(1) <<< (IntegralW - 1)) - 1;
  localparam longint IntegMin = -IntegMax - 1;

  ppid_cfg_t          regs;
  longint             integ;
  longint             last_err;
  logic signed [15:0] drive_due[$];
  int                 fails;

  function automatic longint clip(input longint x, input logic [14:0] lim);
    longint m;
    m = longint'({49'd0, lim});
    if (x > m) return m;
    if (x < -m) return -m;
    return x;
  endfunction

  // Advance the integral and last error by one sample, return the drive it yields.
  function automatic logic signed [15:0] next_drive(input logic direct,
                                                    input logic signed [15:0] smp);
    longint err, acc, p_term, i_term, d_term;
    err = direct ? longint'(smp) : longint'($signed(regs.setpoint)) - longint'(smp);
    acc = integ + err;
    if (acc > IntegMax) acc = IntegMax;
    if (acc < IntegMin) acc = IntegMin;
    integ = acc;
    p_term = clip((longint'($signed(regs.gain_p)) * err) >>> 8, regs.limit_p);
    // drop the integral term for setpoint-mode errors below the separation threshold
    if (!direct && err < longint'($signed(regs.sep_threshold))) begin
      i_term = 0;
    end else begin
      i_term = clip((longint'($signed(regs.gain_i)) * acc) >>> 8, regs.limit_i);
    end
    d_term = clip((longint'($signed(regs.gain_d)) * (err - last_err)) >>> 8, LimitD);
    last_err = err;
    return 16'(clip(p_term + i_term + d_term, regs.limit_total));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic signed [15:0] want;
    if (!rst_ni) begin
      regs = '0;
      regs.limit_p = 15'h7FFF;
      regs.limit_i = 15'h7FFF;
      regs.limit_total = 15'h7FFF;
      integ = 0;
      last_err = 0;
      drive_due.delete();
      fails = 0;
      fail_cnt_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (ppid_reg_e'(cfg_idx_i))
          RegSetpoint:     regs.setpoint      = cfg_wdata_i[15:0];
          RegGainP:        regs.gain_p        = cfg_wdata_i[15:0];
          RegGainI:        regs.gain_i        = cfg_wdata_i[15:0];
          RegGainD:        regs.gain_d        = cfg_wdata_i[15:0];
          RegSepThreshold: regs.sep_threshold = cfg_wdata_i[16:0];
          RegLimitP:       regs.limit_p       = cfg_wdata_i[14:0];
          RegLimitI:       regs.limit_i       = cfg_wdata_i[14:0];
          RegLimitTotal:   regs.limit_total   = cfg_wdata_i[14:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (drive_due.size() == 0) begin
          $error("drive: unexpected beat, actual %0d", drive_i);
          fails++;
        end else begin
          want = drive_due.pop_front();
          if (want !== drive_i) begin
            $error("drive mismatch: expected %0d, actual %0d", want, drive_i);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        drive_due.push_back(next_drive(cmd_i, sample_i));
      end
      fail_cnt_o <= fails;
      pending_o <= drive_due.size();
    end
  end

endmodule

### sim/position_pid_controller_unit_tb.sv
module position_pid_controller_unit_tb;
  import ppid_pkg::*;

  localparam int IntegW = 32;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [2:0]         cfg_idx_i   = 3'b000;
  logic [16:0]        cfg_wdata_i = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic               cmd_i       = 1'b0;
  logic signed [15:0] sample_i    = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [15:0] drive_o;

  int fail_cnt;
  int pending;
  int burst_left;
  bit gaps_on;
  bit rx_free;
  int cur_sp;
  int cur_sep;

  position_pid_controller_unit #(
    .INTEGRAL_WIDTH(IntegW)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .sample_i   (sample_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .drive_o    (drive_o)
  );

  ppid_drive_checker #(
    .IntegralW(IntegW)
  ) checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_i (in_ready_o),
    .cmd_i      (cmd_i),
    .sample_i   (sample_i),
    .out_valid_i(out_valid_o),
    .out_ready_i(out_ready_i),
    .drive_i    (drive_o),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic set_reg(input ppid_reg_e r, input int v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= r;
    cfg_wdata_i <= 17'(v);
    @(posedge clk_i);
  endtask

  task automatic apply_cfg(input int sp, input int kp, input int ki, input int kd,
                           input int sep, input int lp, input int li, input int lt);
    cur_sp = sp;
    cur_sep = sep;
    set_reg(RegSetpoint, sp);
    set_reg(RegGainP, kp);
    set_reg(RegGainI, ki);
    set_reg(RegGainD, kd);
    set_reg(RegSepThreshold, sep);
    set_reg(RegLimitP, lp);
    set_reg(RegLimitI, li);
    set_reg(RegLimitTotal, lt);
    cfg_we_i <= 1'b0;
  endtask

  // Offer one beat; open a new burst, after a random gap if gaps are on, when the current one runs out.
  task automatic push_item(input logic c, input logic signed [15:0] s);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i <= 1'b1;
    cmd_i <= c;
    sample_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
  endtask

  // Drop valid and hold until every predicted drive has come out.
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic int pick_signed(input int lo, input int hi);
    case ($urandom_range(0, 5))
      0: return lo;
      1: return hi;
      2: return int'($urandom_range(0, 1024)) - 512;
      default: return lo + int'($urandom_range(0, hi - lo));
    endcase
  endfunction

  function automatic int pick_limit();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 32767;
      2: return int'($urandom_range(1, 400));
      default: return int'($urandom_range(0, 32767));
    endcase
  endfunction

  task automatic push_random();
    int near;
    logic c;
    logic signed [15:0] s;
    c = 1'($urandom);
    s = 16'($urandom);
    case ($urandom_range(0, 7))
      0: s = 16'sh8000;
      1: s = 16'sh7FFF;
      2, 3: begin
        // aim the error at the separation threshold
        near = cur_sp - cur_sep + int'($urandom_range(0, 4)) - 2;
        c = 1'b0;
        if (near >= -32768 && near <= 32767) s = 16'(near);
      end
      default: ;
    endcase
    push_item(c, s);
  endtask

  initial begin : receiver
    int seg_left;
    int mode;
    int seen;
    bit held;
    seg_left = 0;
    mode = 0;
    seen = 0;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) seen++;
      if (rx_free) begin
        out_ready_i <= 1'b1;
      end else if (!held && seen >= 500) begin
        // long hold-off so the pipeline backs up into the input
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (120) @(posedge clk_i);
      end else begin
        if (seg_left == 0) begin
          mode = $urandom_range(0, 2);
          seg_left = $urandom_range(1, 40);
        end
        seg_left--;
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom);
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    int phase;
    gaps_on = 1'b1;
    rx_free = 1'b0;
    burst_left = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // error at and just below the threshold, sample extremes in both modes
    apply_cfg(1000, 256, 16, -128, 0, 32767, 20000, 32767);
    push_item(1'b0, 16'sd1000);
    push_item(1'b0, 16'sd1001);
    push_item(1'b0, 16'sh8000);
    push_item(1'b0, 16'sh7FFF);
    push_item(1'b1, 16'sh7FFF);
    push_item(1'b1, 16'sh8000);
    push_item(1'b1, 16'sd0);
    settle();
    // unit gains: floor rounding of small negative products, top threshold
    apply_cfg(32767, 1, 1, 1, 65535, 32767, 32767, 32767);
    push_item(1'b1, -16'sd1);
    push_item(1'b1, 16'sd1);
    push_item(1'b1, -16'sd255);
    push_item(1'b0, 16'sh8000);
    push_item(1'b0, 16'sh7FFF);
    settle();
    // most negative gains, bottom threshold, zero term limits
    apply_cfg(-32768, -32768, -32768, -32768, -65536, 0, 0, 32767);
    push_item(1'b0, 16'sh7FFF);
    push_item(1'b0, 16'sh8000);
    push_item(1'b1, 16'sh8000);
    push_item(1'b1, 16'sh7FFF);
    settle();
    // zero total limit
    apply_cfg(0, 32767, 32767, 32767, 0, 32767, 32767, 0);
    push_item(1'b1, 16'sh7FFF);
    push_item(1'b1, 16'sh8000);

    for (phase = 0; phase < 6; phase++) begin
      settle();
      case (phase)
        1: apply_cfg(32767, 32767, 32767, 32767, 65535, 32767, 32767, 32767);
        2: apply_cfg(-32768, -32768, -32768, -32768, -65536,
                     pick_limit(), pick_limit(), pick_limit());
        default: apply_cfg(pick_signed(-32768, 32767), pick_signed(-32768, 32767),
                           pick_signed(-32768, 32767), pick_signed(-32768, 32767),
                           pick_signed(-65536, 65535), pick_limit(), pick_limit(),
                           pick_limit());
      endcase
      repeat (240) push_random();
    end
    settle();

    // back-to-back beats with a free receiver at the integral gain extremes
    rx_free = 1'b1;
    gaps_on = 1'b0;
    apply_cfg(32767, 200, 32767, 64, 65535, 32767, 32767, 32767);
    repeat (8) push_item(1'b0, 16'sh8000);
    repeat (4) push_item(1'b1, 16'sh7FFF);
    settle();
    apply_cfg(-32768, -200, -32768, 64, -65536, 32767, 32767, 32767);
    repeat (8) push_item(1'b0, 16'sh7FFF);
    repeat (4) push_item(1'b1, 16'sh8000);
    settle();
    rx_free = 1'b0;

    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/ppid_pkg.sv
rtl/core/ppid_front.sv
rtl/core/ppid_terms.sv
rtl/core/ppid_sum.sv
rtl/core/position_pid_controller_unit.sv
rtl/core/ppid_checker.sv
sim/ppid_drive_checker.sv
sim/position_pid_controller_unit_tb.sv
